// ===== hdl/video_ram_access_port_core_macros.svh =====
// assertion macros for the video ram access port
`ifndef VIDEO_RAM_ACCESS_PORT_CORE_MACROS_SVH
`define VIDEO_RAM_ACCESS_PORT_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define VRAP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define VRAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define VRAP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define VRAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/vrap_pkg.sv =====
package vrap_pkg;

    // word address width
    localparam int ADDR_BITS  = 15;
    // byte address into the video memory
    localparam int MEM_ADDR_W = ADDR_BITS + 1;
    localparam int MEM_DEPTH  = 1 << MEM_ADDR_W;

    // field widths on the ports
    localparam int REQ_W      = 3;
    localparam int BYTE_W     = 8;
    localparam int OUT_ADDR_W = 15;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    typedef logic [REQ_W-1:0] t_req;

    localparam t_req REQ_SET_MODE   = 3'd0;
    localparam t_req REQ_ADDR_LOW   = 3'd1;
    localparam t_req REQ_ADDR_HIGH  = 3'd2;
    localparam t_req REQ_WRITE_LOW  = 3'd3;
    localparam t_req REQ_WRITE_HIGH = 3'd4;
    localparam t_req REQ_READ_LOW   = 3'd5;
    localparam t_req REQ_READ_HIGH  = 3'd6;

    localparam logic [1:0] STEP_1   = 2'd0;
    localparam logic [1:0] STEP_32  = 2'd1;
    localparam logic [1:0] STEP_64  = 2'd2;
    localparam logic [1:0] STEP_128 = 2'd3;

    // memory request from the address unit
    typedef struct packed {
        logic                  wr_en;
        logic                  rd_en;
        logic [MEM_ADDR_W-1:0] byte_addr;
        logic [BYTE_W-1:0]     wdata;
    } t_mem_req;

    function automatic logic [7:0] step_words(input logic [1:0] code);
        logic [7:0] words;
        unique case (code)
            STEP_1:   words = 8'd1;
            STEP_32:  words = 8'd32;
            STEP_64:  words = 8'd64;
            STEP_128: words = 8'd128;
            default:  words = 8'd1;
        endcase
        return words;
    endfunction

endpackage

// ===== hdl/vrap_mem.sv =====
module vrap_mem (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic                            i_re,
    input  logic [vrap_pkg::MEM_ADDR_W-1:0] i_addr,
    input  logic [vrap_pkg::BYTE_W-1:0]     i_wdata,
    output logic [vrap_pkg::BYTE_W-1:0]     o_rdata
);

    logic [vrap_pkg::BYTE_W-1:0] r_mem [vrap_pkg::MEM_DEPTH];
    logic [vrap_pkg::BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/vrap_addr.sv =====
module vrap_addr (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  vrap_pkg::t_req                 i_req_type,
    input  logic [vrap_pkg::BYTE_W-1:0]    i_write_byte,
    output vrap_pkg::t_mem_req             o_mem_req,
    output logic [vrap_pkg::ADDR_BITS-1:0] o_addr_next
);

    logic [vrap_pkg::ADDR_BITS-1:0] r_addr;
    logic [vrap_pkg::ADDR_BITS-1:0] n_addr;
    logic                           r_adv_high;
    logic                           n_adv_high;
    logic [1:0]                     r_step;
    logic [1:0]                     n_step;

    logic [15:0]                    w_load;
    logic [vrap_pkg::ADDR_BITS-1:0] w_stepped;
    logic                           w_half;
    logic                           w_wr;
    logic                           w_rd;

    assign w_stepped = r_addr + vrap_pkg::ADDR_BITS'(vrap_pkg::step_words(r_step));
    assign w_load    = 16'(r_addr);

    always_comb begin
        n_addr     = r_addr;
        n_adv_high = r_adv_high;
        n_step     = r_step;
        w_half     = 1'b0;
        w_wr       = 1'b0;
        w_rd       = 1'b0;
        unique case (i_req_type)
            vrap_pkg::REQ_SET_MODE: begin
                n_adv_high = i_write_byte[7];
                n_step     = i_write_byte[1:0];
            end
            vrap_pkg::REQ_ADDR_LOW: begin
                n_addr = vrap_pkg::ADDR_BITS'({w_load[15:8], i_write_byte});
            end
            vrap_pkg::REQ_ADDR_HIGH: begin
                n_addr = vrap_pkg::ADDR_BITS'({i_write_byte, w_load[7:0]});
            end
            vrap_pkg::REQ_WRITE_LOW: begin
                w_wr = 1'b1;
            end
            vrap_pkg::REQ_WRITE_HIGH: begin
                w_wr   = 1'b1;
                w_half = 1'b1;
            end
            vrap_pkg::REQ_READ_LOW: begin
                w_rd = 1'b1;
            end
            vrap_pkg::REQ_READ_HIGH: begin
                w_rd   = 1'b1;
                w_half = 1'b1;
            end
            default: begin
            end
        endcase
        // advance after the access to the half the mode names
        if ((w_wr || w_rd) && (w_half == r_adv_high)) begin
            n_addr = w_stepped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr     <= '0;
            r_adv_high <= 1'b0;
            r_step     <= vrap_pkg::STEP_1;
        end else if (i_accept) begin
            r_addr     <= n_addr;
            r_adv_high <= n_adv_high;
            r_step     <= n_step;
        end
    end

    assign o_mem_req.wr_en     = i_accept && w_wr;
    assign o_mem_req.rd_en     = i_accept && w_rd;
    assign o_mem_req.byte_addr = {r_addr, w_half};
    assign o_mem_req.wdata     = i_write_byte;
    assign o_addr_next         = n_addr;

endmodule

// ===== hdl/video_ram_access_port_core.sv =====
// output: a word appears on the output in the cycle after it is accepted
// throughput: one word per cycle while the output side takes each result,
// set by the single byte port of the video memory (one access per word)
// reset: word address, step and advance flag clear; video memory is not
// cleared and holds undefined bytes until written
`include "video_ram_access_port_core_macros.svh"

module video_ram_access_port_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [vrap_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // write_byte
    input  logic [vrap_pkg::REQ_W-1:0]           s_axis_tuser,  // req_type
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [vrap_pkg::OUT_TDATA_W-1:0]     m_axis_tdata   // read_byte, word_address
);

    logic                           w_accept;
    vrap_pkg::t_mem_req             w_mem_req;
    logic [vrap_pkg::ADDR_BITS-1:0] w_addr_next;
    logic [vrap_pkg::BYTE_W-1:0]    w_rdata;

    logic                           r_valid;
    logic                           r_is_read;
    logic [vrap_pkg::ADDR_BITS-1:0] r_addr;
    logic [vrap_pkg::BYTE_W-1:0]    w_read_byte;

    // no word is taken while reset is held
    assign s_axis_tready = i_rst_n && (!r_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    vrap_addr u_addr (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_req_type   (s_axis_tuser),
        .i_write_byte (s_axis_tdata[vrap_pkg::BYTE_W-1:0]),
        .o_mem_req    (w_mem_req),
        .o_addr_next  (w_addr_next)
    );

    vrap_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_req.wr_en),
        .i_re    (w_mem_req.rd_en),
        .i_addr  (w_mem_req.byte_addr),
        .i_wdata (w_mem_req.wdata),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_is_read <= w_mem_req.rd_en;
            r_addr    <= w_addr_next;
        end
    end

    assign w_read_byte   = r_is_read ? w_rdata : '0;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {1'b0, vrap_pkg::OUT_ADDR_W'(r_addr), w_read_byte};

    `VRAP_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, w_accept, m_axis_tvalid, "accepted word gave no result")
    `VRAP_ASSERT_NOW(a_no_overrun, i_clk, i_rst_n, r_valid && !m_axis_tready, !s_axis_tready, "input taken while result stalled")
    `VRAP_ASSERT_NOW(a_zero_on_nonread, i_clk, i_rst_n, r_valid && !r_is_read, m_axis_tdata[7:0] == 8'd0, "non-read result carries data")
    `VRAP_ASSERT_NOW(a_mem_on_accept, i_clk, i_rst_n, w_mem_req.rd_en || w_mem_req.wr_en, w_accept, "memory access without accepted word")

endmodule
